@@ sv/dependency_graph_batch_scheduler_macros.svh @@
// Assertion macros for the dependency graph batch scheduler.
// Used by the top level only; no other dependencies.
`ifndef DEPENDENCY_GRAPH_BATCH_SCHEDULER_MACROS_SVH
`define DEPENDENCY_GRAPH_BATCH_SCHEDULER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define DGBS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dgbs assertion failed");
// Next-cycle implication
`define DGBS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dgbs assertion failed");
`else
`define DGBS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define DGBS_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ sv/dgbs_pkg.sv @@
// Shared types and constants for the dependency graph batch scheduler.
// No dependencies; used by dgbs_ctrl, dgbs_dp and the top level.
`timescale 1ns / 1ps
package dgbs_pkg;
   localparam int NUM_SYS = 32;
   localparam int ID_W    = 5;
   localparam int CNT_W   = 6;
   localparam int DEG_W   = 6;

   localparam logic [1:0] MODE_ADD   = 2'd0;
   localparam logic [1:0] MODE_QUERY = 2'd1;
   localparam logic [1:0] MODE_BUILD = 2'd2;
   localparam logic [1:0] MODE_CLEAR = 2'd3;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND   = 3'd1;
   localparam logic [2:0] ST_SELF        = 3'd2;
   localparam logic [2:0] ST_WOULD_CYCLE = 3'd3;
   localparam logic [2:0] ST_GRAPH_CYCLE = 3'd4;

   typedef struct packed {
      logic [1:0]      mode;
      logic [ID_W-1:0] first_system;
      logic [ID_W-1:0] second_system;
   } req_type;

   typedef struct packed {
      logic [2:0]      status;
      logic            reachable;
      logic [ID_W-1:0] system_id;
      logic [ID_W-1:0] batch_index;
      logic            last;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic       load;
      logic       row_b;
      logic       path_init;
      logic       path_step;
      logic       add_edge;
      logic       clear_edges;
      logic       build_init;
      logic       deg_step;
      logic       front;
      logic       dec_step;
      logic       place;
      logic       emit_step;
      logic       respond;
      logic [2:0] status;
      logic       reach;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic [1:0] mode;
      logic       ids_bad;
      logic       self_edge;
      logic       edge_exists;
      logic       n_zero;
      logic       sweep_done;
      logic       hit;
      logic       row_n_last;
      logic       all_placed;
      logic       front_empty;
      logic       emit_done;
   } stat_type;
endpackage

@@ sv/dgbs_ctrl.sv @@
// Sequencer for the dependency graph batch scheduler.
// Depends on dgbs_pkg; drives dgbs_dp through cmd_type and reads stat_type.
`timescale 1ns / 1ps
module dgbs_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  dgbs_pkg::stat_type stat,
   output dgbs_pkg::cmd_type  cmd
);
   import dgbs_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_INIT   = 4'd2;
   localparam logic [3:0] S_SWEEP  = 4'd3;
   localparam logic [3:0] S_RESULT = 4'd4;
   localparam logic [3:0] S_DEG    = 4'd5;
   localparam logic [3:0] S_FRONT  = 4'd6;
   localparam logic [3:0] S_DEC    = 4'd7;
   localparam logic [3:0] S_EMIT   = 4'd8;

   logic [3:0] state_ff, state_in;

   assign busy = (state_ff != S_IDLE);

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.status = ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (stat.mode)
               MODE_ADD: begin
                  if (stat.ids_bad) begin
                     cmd.respond = 1'b1;
                     cmd.status  = ST_NOT_FOUND;
                     state_in    = S_IDLE;
                  end else if (stat.self_edge) begin
                     cmd.respond = 1'b1;
                     cmd.status  = ST_SELF;
                     state_in    = S_IDLE;
                  end else if (stat.edge_exists) begin
                     cmd.respond = 1'b1;
                     state_in    = S_IDLE;
                  end else begin
                     cmd.row_b = 1'b1;
                     state_in  = S_INIT;
                  end
               end
               MODE_QUERY: begin
                  if (stat.ids_bad) begin
                     cmd.respond = 1'b1;
                     cmd.status  = ST_NOT_FOUND;
                     state_in    = S_IDLE;
                  end else begin
                     state_in = S_INIT;
                  end
               end
               MODE_BUILD: begin
                  if (stat.n_zero) begin
                     state_in = S_IDLE;
                  end else begin
                     cmd.build_init = 1'b1;
                     state_in       = S_DEG;
                  end
               end
               MODE_CLEAR: begin
                  cmd.clear_edges = 1'b1;
                  cmd.respond     = 1'b1;
                  state_in        = S_IDLE;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_INIT: begin
            cmd.path_init = 1'b1;
            state_in      = S_SWEEP;
         end
         S_SWEEP: begin
            cmd.path_step = 1'b1;
            if (stat.sweep_done) state_in = S_RESULT;
         end
         S_RESULT: begin
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
            if (stat.mode == MODE_ADD) begin
               if (stat.hit) cmd.status = ST_WOULD_CYCLE;
               else cmd.add_edge = 1'b1;
            end else begin
               cmd.reach = 1'b1;
            end
         end
         S_DEG: begin
            cmd.deg_step = 1'b1;
            if (stat.row_n_last) state_in = S_FRONT;
         end
         S_FRONT: begin
            if (stat.all_placed) begin
               state_in = S_EMIT;
            end else if (stat.front_empty) begin
               cmd.respond = 1'b1;
               cmd.status  = ST_GRAPH_CYCLE;
               state_in    = S_IDLE;
            end else begin
               cmd.front = 1'b1;
               state_in  = S_DEC;
            end
         end
         S_DEC: begin
            cmd.dec_step = 1'b1;
            if (stat.row_n_last) begin
               cmd.place = 1'b1;
               state_in  = S_FRONT;
            end
         end
         S_EMIT: begin
            cmd.emit_step = 1'b1;
            if (stat.emit_done) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end
endmodule

@@ sv/dgbs_dp.sv @@
// Datapath: edge matrix, in-degree counters, masks, levels, result register.
// Depends on dgbs_pkg; commanded by dgbs_ctrl.
`timescale 1ns / 1ps
module dgbs_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [dgbs_pkg::CNT_W-1:0]     csr_data,
   input  dgbs_pkg::req_type              req_payload,
   input  dgbs_pkg::cmd_type              cmd,
   output dgbs_pkg::stat_type             stat,
   output logic                           rsp_strobe,
   output dgbs_pkg::rsp_type              rsp_payload
);
   import dgbs_pkg::*;

   logic [CNT_W-1:0]   count_ff, count_in;
   req_type            req_ff, req_in;
   logic [ID_W-1:0]    row_ff, row_in;
   logic [NUM_SYS-1:0] edge_ff [NUM_SYS];
   logic [NUM_SYS-1:0] edge_in [NUM_SYS];
   logic [DEG_W-1:0]   deg_ff [NUM_SYS];
   logic [DEG_W-1:0]   deg_in [NUM_SYS];
   logic [ID_W-1:0]    level_ff [NUM_SYS];
   logic [ID_W-1:0]    level_in [NUM_SYS];
   logic [NUM_SYS-1:0] visited_ff, visited_in;
   logic               changed_ff, changed_in;
   logic [NUM_SYS-1:0] frontier_ff, frontier_in;
   logic [NUM_SYS-1:0] placed_ff, placed_in;
   logic [CNT_W-1:0]   batch_ff, batch_in;
   logic [ID_W-1:0]    emit_b_ff, emit_b_in;
   logic [ID_W-1:0]    last_id_ff, last_id_in;
   logic               strobe_ff, strobe_in;
   rsp_type            rsp_ff, rsp_in;

   logic [CNT_W-1:0]   n;
   logic [CNT_W-1:0]   n_m1;
   logic [ID_W-1:0]    n_last;
   logic [NUM_SYS-1:0] valid;
   logic [NUM_SYS-1:0] cur_row;
   logic [NUM_SYS-1:0] new_bits;
   logic [NUM_SYS-1:0] front_calc;
   logic               hit;
   logic               row_n_last;
   logic               emit_hit;
   logic               emit_last_batch;

   // Effective task count and live mask
   assign n      = (count_ff > CNT_W'(NUM_SYS)) ? CNT_W'(NUM_SYS) : count_ff;
   assign n_m1   = n - CNT_W'(1);
   assign n_last = n_m1[ID_W-1:0];
   assign valid  = (n == CNT_W'(NUM_SYS)) ? '1 :
                   ((NUM_SYS'(1) << n) - NUM_SYS'(1));

   // Row under the cursor and sweep growth
   assign cur_row  = edge_ff[row_ff];
   assign new_bits = visited_ff[row_ff] ? (cur_row & ~visited_ff) : '0;

   // Ready set: live, no pending predecessors, not yet placed
   always_comb begin
      for (int i = 0; i < NUM_SYS; i++) begin
         front_calc[i] = valid[i] && (deg_ff[i] == '0) && !placed_ff[i];
      end
   end

   assign hit = (req_ff.mode == MODE_ADD) ? visited_ff[req_ff.first_system] :
                                            visited_ff[req_ff.second_system];
   assign row_n_last      = (row_ff == n_last);
   assign emit_hit        = (level_ff[row_ff] == emit_b_ff);
   assign emit_last_batch = ({1'b0, emit_b_ff} == (batch_ff - CNT_W'(1)));

   // Status to controller
   always_comb begin
      stat.mode        = req_ff.mode;
      stat.ids_bad     = ({1'b0, req_ff.first_system} >= n) ||
                         ({1'b0, req_ff.second_system} >= n);
      stat.self_edge   = (req_ff.first_system == req_ff.second_system);
      stat.edge_exists = cur_row[req_ff.second_system];
      stat.n_zero      = (n == '0);
      stat.sweep_done  = (row_ff == '1) && !changed_ff && (new_bits == '0);
      stat.hit         = hit;
      stat.row_n_last  = row_n_last;
      stat.all_placed  = (placed_ff == valid);
      stat.front_empty = (front_calc == '0);
      stat.emit_done   = row_n_last && emit_last_batch;
   end

   // Next-state logic
   always_comb begin
      count_in    = csr_we ? csr_data : count_ff;
      req_in      = cmd.load ? req_payload : req_ff;
      edge_in     = edge_ff;
      deg_in      = deg_ff;
      level_in    = level_ff;
      visited_in  = visited_ff;
      changed_in  = changed_ff;
      frontier_in = frontier_ff;
      placed_in   = placed_ff;
      batch_in    = batch_ff;
      emit_b_in   = emit_b_ff;
      last_id_in  = last_id_ff;

      // Row cursor
      row_in = row_ff;
      if (cmd.load) row_in = req_payload.first_system;
      if (cmd.row_b) row_in = req_ff.second_system;
      if (cmd.path_step || cmd.deg_step || cmd.dec_step || cmd.emit_step) begin
         row_in = row_ff + ID_W'(1);
      end
      if (cmd.emit_step && row_n_last) row_in = '0;
      if (cmd.path_init || cmd.build_init || cmd.front || cmd.place) row_in = '0;

      // Reachability closure sweeps
      if (cmd.path_init) begin
         visited_in = cur_row;
         changed_in = 1'b0;
      end
      if (cmd.path_step) begin
         visited_in = visited_ff | new_bits;
         changed_in = (row_ff == '1) ? 1'b0 : (changed_ff || (new_bits != '0));
      end

      // Edge matrix updates
      if (cmd.clear_edges) begin
         for (int i = 0; i < NUM_SYS; i++) edge_in[i] = '0;
      end
      if (cmd.add_edge) edge_in[req_ff.first_system][req_ff.second_system] = 1'b1;

      // In-degree counters
      for (int j = 0; j < NUM_SYS; j++) begin
         if (cmd.build_init) begin
            deg_in[j] = '0;
         end else if (cmd.deg_step) begin
            if (cur_row[j] && valid[j]) deg_in[j] = deg_ff[j] + DEG_W'(1);
         end else if (cmd.dec_step) begin
            if (frontier_ff[row_ff] && cur_row[j] && valid[j] && (deg_ff[j] != '0)) begin
               deg_in[j] = deg_ff[j] - DEG_W'(1);
            end
         end
      end

      // Levelling bookkeeping
      if (cmd.build_init) begin
         placed_in = '0;
         batch_in  = '0;
         emit_b_in = '0;
      end
      if (cmd.front) begin
         frontier_in = front_calc;
         for (int i = 0; i < NUM_SYS; i++) begin
            if (front_calc[i]) level_in[i] = batch_ff[ID_W-1:0];
         end
      end
      if (cmd.dec_step && frontier_ff[row_ff]) last_id_in = row_ff;
      if (cmd.place) begin
         placed_in = placed_ff | frontier_ff;
         batch_in  = batch_ff + CNT_W'(1);
      end
      if (cmd.emit_step && row_n_last) emit_b_in = emit_b_ff + ID_W'(1);

      // Result register
      strobe_in = cmd.respond || (cmd.emit_step && emit_hit);
      rsp_in    = '0;
      if (cmd.respond) begin
         rsp_in.status    = cmd.status;
         rsp_in.reachable = cmd.reach && hit;
         rsp_in.last      = 1'b1;
      end else begin
         rsp_in.status      = ST_OK;
         rsp_in.system_id   = row_ff;
         rsp_in.batch_index = emit_b_ff;
         rsp_in.last        = emit_last_batch && (row_ff == last_id_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= CNT_W'(1);
         strobe_ff <= 1'b0;
         for (int i = 0; i < NUM_SYS; i++) edge_ff[i] <= '0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
         edge_ff   <= edge_in;
      end
   end

   // Payload and scratch registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      row_ff      <= row_in;
      deg_ff      <= deg_in;
      level_ff    <= level_in;
      visited_ff  <= visited_in;
      changed_ff  <= changed_in;
      frontier_ff <= frontier_in;
      placed_ff   <= placed_in;
      batch_ff    <= batch_in;
      emit_b_ff   <= emit_b_in;
      last_id_ff  <= last_id_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_payload = rsp_ff;
endmodule

@@ sv/dependency_graph_batch_scheduler.sv @@
// Top level of the dependency graph batch scheduler.
// Depends on dgbs_pkg, dgbs_ctrl, dgbs_dp and the assertion macro header.
//
//   channel   ports                              transfer
//   request   start, busy, req_payload           start && !busy
//   result    rsp_strobe, rsp_payload            rsp_strobe (one cycle)
//   config    csr_valid, csr_ready, csr_data     csr_valid && csr_ready
//
// Add edge and query answer early on a bad ID (add also on a self or existing
// edge), else after closure sweeps over the edge rows (one row read per cycle),
// up to 32 sweeps. Build: an n-row in-degree pass, then per batch a front step
// and n-row decrement pass, then n-row emit passes. Reset empties the graph and
// sets the task count to 1. Results are registered; the receiver cannot stall.
`timescale 1ns / 1ps
`include "dependency_graph_batch_scheduler_macros.svh"
module dependency_graph_batch_scheduler (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  dgbs_pkg::req_type          req_payload,
   output logic                       rsp_strobe,
   output dgbs_pkg::rsp_type          rsp_payload,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [dgbs_pkg::CNT_W-1:0] csr_data
);
   import dgbs_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   dgbs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   dgbs_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_valid && csr_ready),
      .csr_data    (csr_data),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   // Checks
   `DGBS_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy)
   `DGBS_ASSERT_IMP(a_err_last, clock, reset, rsp_strobe && (rsp_payload.status != ST_OK), rsp_payload.last)
   `DGBS_ASSERT_IMP(a_more_busy, clock, reset, rsp_strobe && !rsp_payload.last, busy)
   `DGBS_ASSERT_IMP(a_reach_ok, clock, reset, rsp_strobe && rsp_payload.reachable, rsp_payload.status == ST_OK)
endmodule
